// ===== rtl/pwm_pulse_measure_top_defines.svh =====
// assertion macros for the pwm pulse measurement block
// used by pwm_pulse_measure_top, expects aclk and aresetn in scope
`ifndef PWM_PULSE_MEASURE_TOP_DEFINES_SVH
`define PWM_PULSE_MEASURE_TOP_DEFINES_SVH

// same-cycle implication, masked while in reset
`define PWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define PWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pwm_meas_pkg.sv =====
// shared types and constants for the pwm pulse measurement block
// no dependencies
package pwm_meas_pkg;

    localparam int FIELD_BITS = 24;
    localparam int DUTY_BITS  = 7;
    localparam int TPU_BITS   = 8;

    localparam logic [TPU_BITS-1:0]   TPU_RESET = 8'd16;
    localparam logic [DUTY_BITS-1:0]  DUTY_FULL = 7'd100;
    localparam logic [FIELD_BITS-1:0] FIELD_MAX = 24'hFFFFFF;

    // edge sequence position
    localparam logic [1:0] EDGE_RISE_ONE = 2'd0;
    localparam logic [1:0] EDGE_FALL     = 2'd1;
    localparam logic [1:0] EDGE_RISE_TWO = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV_W = 5'b00010,
        ST_DIV_P = 5'b00100,
        ST_DIV_D = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

endpackage

// ===== rtl/pwm_pulse_measure_top.sv =====
// pwm pulse measurement top, needs pwm_meas_pkg and pwm_pulse_measure_top_defines.svh
// sequence: first rise and fall beats only store stamps, no result; second rise runs
//   ST_DIV_W, ST_DIV_P, ST_DIV_D, then ST_OUT raises m_tvalid; zero period skips to ST_OUT
// throughput: one shared restoring divider, one quotient bit per cycle, used three times;
//   not ready while dividing or while ST_OUT holds a result until the output register is free
// reset: synchronous active low, clears sequence, first rise and fall stamps, output valid, divisor to 16
`include "pwm_pulse_measure_top_defines.svh"

module pwm_pulse_measure_top #(
    parameter int STAMP_BITS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // edge_time[23:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // pulse_width_us[23:0], period_us[47:24], duty_percent[54:48], rise_one_time[78:55],
    // fall_time[102:79], rise_two_time[126:103], zero pad[127]
    output logic [127:0] m_tdata,
    output logic         m_tuser    // zero_period_error
);

    localparam int SB = STAMP_BITS;
    localparam int DW = SB + pwm_meas_pkg::DUTY_BITS;
    localparam int QW = (SB > pwm_meas_pkg::FIELD_BITS) ? SB : pwm_meas_pkg::FIELD_BITS;
    localparam int CW = $clog2(DW + 1);

    pwm_meas_pkg::state_t state_reg;
    logic [1:0]    edge_reg;
    logic [7:0]    tpu_reg;
    logic [SB-1:0] rise_reg;
    logic [SB-1:0] fall_reg;
    logic [SB-1:0] rise2_reg;
    logic [SB-1:0] high_reg;
    logic [SB-1:0] period_reg;
    logic          err_reg;
    logic [SB-1:0] rem_reg;
    logic [DW-1:0] dvd_reg;
    logic [SB-1:0] dvsr_reg;
    logic [CW-1:0] cnt_reg;
    logic [23:0]   pw_reg;
    logic [23:0]   per_reg;
    logic [6:0]    duty_reg;
    logic          m_tvalid_reg;
    logic [127:0]  m_tdata_reg;
    logic          m_tuser_reg;

    logic [QW-1:0] t_wide;
    logic [SB-1:0] t_val;
    logic [SB-1:0] period_calc;
    logic [SB-1:0] tpu_div;
    logic [SB:0]   rem_sh;
    logic [SB:0]   diff;
    logic          qbit;
    logic [SB-1:0] rem_next;
    logic [DW-1:0] dvd_next;
    logic [QW-1:0] quo_wide;
    logic [23:0]   quo_sat;
    logic [DW-1:0] duty_dvd;
    logic          s_beat;
    logic          out_free;
    logic [QW-1:0] rise_w;
    logic [QW-1:0] fall_w;
    logic [QW-1:0] rise2_w;

    assign t_wide      = QW'(s_tdata);
    assign t_val       = t_wide[SB-1:0];
    assign period_calc = t_val - rise_reg;
    assign tpu_div     = (tpu_reg == 8'd0) ? SB'(1) : SB'(tpu_reg);

    // shared restoring divider step
    assign rem_sh   = {rem_reg, dvd_reg[DW-1]};
    assign diff     = rem_sh - {1'b0, dvsr_reg};
    assign qbit     = ~diff[SB];
    assign rem_next = qbit ? diff[SB-1:0] : rem_sh[SB-1:0];
    assign dvd_next = {dvd_reg[DW-2:0], qbit};

    assign quo_wide = QW'(dvd_next[SB-1:0]);
    assign quo_sat  = (quo_wide > QW'(pwm_meas_pkg::FIELD_MAX)) ?
                      pwm_meas_pkg::FIELD_MAX : quo_wide[23:0];
    assign duty_dvd = DW'(high_reg) * DW'(pwm_meas_pkg::DUTY_FULL);

    assign rise_w  = QW'(rise_reg);
    assign fall_w  = QW'(fall_reg);
    assign rise2_w = QW'(rise2_reg);

    assign s_tready = (state_reg == pwm_meas_pkg::ST_IDLE);
    assign s_beat   = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg <= pwm_meas_pkg::TPU_RESET;
        end else if (cfg_we) begin
            tpu_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pwm_meas_pkg::ST_IDLE;
            edge_reg     <= pwm_meas_pkg::EDGE_RISE_ONE;
            rise_reg     <= '0;
            fall_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != pwm_meas_pkg::ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                pwm_meas_pkg::ST_IDLE: begin
                    if (s_beat) begin
                        case (edge_reg)
                            pwm_meas_pkg::EDGE_FALL: begin
                                fall_reg <= t_val;
                                edge_reg <= pwm_meas_pkg::EDGE_RISE_TWO;
                            end
                            pwm_meas_pkg::EDGE_RISE_TWO: begin
                                edge_reg   <= pwm_meas_pkg::EDGE_RISE_ONE;
                                rise2_reg  <= t_val;
                                high_reg   <= fall_reg - rise_reg;
                                period_reg <= period_calc;
                                rem_reg    <= '0;
                                dvd_reg    <= {fall_reg - rise_reg, 7'd0};
                                dvsr_reg   <= tpu_div;
                                cnt_reg    <= CW'(SB);
                                if (period_calc == '0) begin
                                    err_reg   <= 1'b1;
                                    state_reg <= pwm_meas_pkg::ST_OUT;
                                end else begin
                                    err_reg   <= 1'b0;
                                    state_reg <= pwm_meas_pkg::ST_DIV_W;
                                end
                            end
                            default: begin
                                rise_reg <= t_val;
                                edge_reg <= pwm_meas_pkg::EDGE_FALL;
                            end
                        endcase
                    end
                end
                pwm_meas_pkg::ST_DIV_W: begin
                    if (cnt_reg == CW'(1)) begin
                        pw_reg    <= quo_sat;
                        rem_reg   <= '0;
                        dvd_reg   <= {period_reg, 7'd0};
                        cnt_reg   <= CW'(SB);
                        state_reg <= pwm_meas_pkg::ST_DIV_P;
                    end else begin
                        rem_reg <= rem_next;
                        dvd_reg <= dvd_next;
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                pwm_meas_pkg::ST_DIV_P: begin
                    if (cnt_reg == CW'(1)) begin
                        per_reg   <= quo_sat;
                        rem_reg   <= '0;
                        dvd_reg   <= duty_dvd;
                        dvsr_reg  <= period_reg;
                        cnt_reg   <= CW'(DW);
                        state_reg <= pwm_meas_pkg::ST_DIV_D;
                    end else begin
                        rem_reg <= rem_next;
                        dvd_reg <= dvd_next;
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                pwm_meas_pkg::ST_DIV_D: begin
                    rem_reg <= rem_next;
                    dvd_reg <= dvd_next;
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        duty_reg  <= (dvd_next > DW'(pwm_meas_pkg::DUTY_FULL)) ?
                                     pwm_meas_pkg::DUTY_FULL : dvd_next[6:0];
                        state_reg <= pwm_meas_pkg::ST_OUT;
                    end
                end
                pwm_meas_pkg::ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= err_reg;
                        if (err_reg) begin
                            m_tdata_reg <= '0;
                        end else begin
                            m_tdata_reg <= {1'b0, rise2_w[23:0], fall_w[23:0], rise_w[23:0],
                                            duty_reg, per_reg, pw_reg};
                        end
                        state_reg <= pwm_meas_pkg::ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= pwm_meas_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `PWM_ASSERT_NOW(a_duty_range, m_tvalid, m_tdata[54:48] <= pwm_meas_pkg::DUTY_FULL,
        "duty above 100")
    `PWM_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata == 128'd0, "error beat not zero")
    `PWM_ASSERT_NEXT(a_busy_after_rise2,
        s_beat && edge_reg == pwm_meas_pkg::EDGE_RISE_TWO, !s_tready,
        "ready right after second rise")
    `PWM_ASSERT_NOW(a_edge_code, 1'b1, edge_reg != 2'd3, "unused edge index reached")

endmodule
